// File: design/sobel_edge_threshold_unit_defines.svh
// Assertion macros shared by the checker of the Sobel edge threshold unit.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef SOBEL_EDGE_THRESHOLD_UNIT_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_UNIT_DEFINES_SVH

// A property that must hold in the same cycle as its condition.
`define SET_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A property that must hold in the cycle after its condition.
`define SET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/set_pkg.sv
// Types and constants of the Sobel edge threshold unit.
// No dependencies; used by the top level, the checker and the bench.
package set_pkg;

	// Configuration register indexes.
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t REG_IMAGE_WIDTH    = 2'd0;
	localparam cfg_index_t REG_IMAGE_HEIGHT   = 2'd1;
	localparam cfg_index_t REG_EDGE_THRESHOLD = 2'd2;
	localparam int CFG_DATA_W = 13;

	// Reset values of the registers.
	localparam logic [11:0] RST_WIDTH     = 12'd640;
	localparam logic [12:0] RST_HEIGHT    = 13'd480;
	localparam logic [11:0] RST_THRESHOLD = 12'd128;

	// Q0.10 luminance weights (0.241, 0.691, 0.068).
	localparam logic [9:0] WGT_RED   = 10'd247;
	localparam logic [9:0] WGT_GREEN = 10'd708;
	localparam logic [9:0] WGT_BLUE  = 10'd70;

	localparam logic [31:0] NO_EDGE_PIXEL = 32'hffff_ffff;
	localparam logic [31:0] EDGE_PIXEL    = 32'hff10_1010;

	// Control that travels with each beat down the pipeline.
	typedef struct packed {
		logic pixel;    // pixel beat, not a flush beat
		logic res;      // this beat releases a result
		logic interior; // result comes from the gradient
		logic last;     // result belongs to the frame's final pixel
	} ctl_t;

	// Square root digit recurrence state.
	typedef struct packed {
		logic [8:0] rem;
		logic [7:0] root;
	} sq_t;

	// One step of the restoring square root: brings in two radicand bits.
	function automatic sq_t sqrt_step(sq_t s, logic [1:0] pair);
		logic [10:0] r;
		logic [10:0] t;
		sq_t o;
		r = {s.rem, pair};
		t = {1'b0, s.root, 2'b01};
		if (r >= t) begin
			r = r - t;
			o.root = {s.root[6:0], 1'b1};
		end else begin
			o.root = {s.root[6:0], 1'b0};
		end
		o.rem = r[8:0];
		return o;
	endfunction

endpackage

// File: design/set_if.sv
// Stream interfaces of the Sobel edge threshold unit: pixel beats in, results out.
// Depends on nothing but the handshake convention valid and ready.
interface set_pix_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] pixel_in;
	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

interface set_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_out;
	logic        is_edge;
	logic        last_of_frame;
	modport source (output valid, output pixel_out, output is_edge, output last_of_frame,
		input ready);
	modport sink (input valid, input pixel_out, input is_edge, input last_of_frame,
		output ready);
endinterface

// File: design/sobel_edge_threshold_unit.sv
// Sobel edge detector with an L1 gradient threshold over a raster pixel stream.
// Depends on set_pkg and the interfaces in set_if.sv.
//
// Usage:
// pix_in carries beats in raster order: mode 0 is an ARGB pixel, mode 1 a flush
// beat that drains one result still owed. res_out carries the results, one per
// beat that releases one; a pixel beat releases the result for the pixel that
// lies width+1 positions back once that many are owed.
// The configuration port writes image_width, image_height and edge_threshold
// by index; writing a size restarts the frame. Write only while the block is idle.
// Throughput: one beat per cycle while res_out is not stalled. A beat passes the
// luminance path (squares, weighted products, sum, four square root stages), the
// row store read and the gradient and threshold stages before it loads the result
// register.
// Reset clears the pipeline, the frame position, the owed count and the window;
// the row stores hold no reset value, and only written entries reach a result.
// When res_out stalls, the whole pipeline holds and pix_in.ready drops in the
// same cycle; nothing is lost or repeated. Border pixels give no edge.
module sobel_edge_threshold_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  set_pkg::cfg_index_t            cfg_index,
	input  logic [set_pkg::CFG_DATA_W-1:0] cfg_data,
	set_pix_if.sink                        pix_in,
	set_res_if.source                      res_out
);
	import set_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WU_W = $clog2(MAX_WIDTH + 1);
	localparam int HU_W = $clog2(MAX_HEIGHT + 1);
	localparam int PW   = $clog2(MAX_WIDTH + 2);

	// Configuration registers.
	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [11:0] thr_q;
	logic        restart;

	// Frame position and owed results.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] pend_q;

	// Pipeline.
	logic adv, accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ctl_t ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic [CW-1:0] col_s1, col_s2, col_s3, col_s4, col_s5, col_s6, col_s7;
	logic [15:0] r2_s1, g2_s1, b2_s1;
	logic [25:0] pr_s2, pg_s2, pb_s2;
	logic [26:0] sum;
	logic [15:0] v_rad_s3, v_rad_s4, v_rad_s5, v_rad_s6;
	sq_t sq_s4, sq_s5, sq_s6, sq_s7;
	sq_t sq4_a, sq5_a, sq6_a, sq7_a;
	sq_t sq4_b, sq5_b, sq6_b, sq7_b;
	logic [7:0] rd_up_q, rd_mid_q;
	logic [7:0] win_q [9];
	logic [7:0] wn [9];
	logic signed [10:0] dx_s8, dy_s8;
	logic [9:0] ax, ay;
	logic [10:0] power;
	logic edge_hit;
	logic [31:0] pix_s9;
	logic edge_s9;

	// Row stores.
	logic [7:0] upper_mem [MAX_WIDTH];
	logic [7:0] middle_mem [MAX_WIDTH];

	// Used sizes, clamped to the supported range.
	logic [31:0] w32, h32;
	logic [WU_W-1:0] wu;
	logic [HU_W-1:0] hu;

	always_comb begin
		w32 = 32'(width_q);
		h32 = 32'(height_q);
		if (w32 < 32'd3) begin
			w32 = 32'd3;
		end else if (w32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end
		if (h32 < 32'd3) begin
			h32 = 32'd3;
		end else if (h32 > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end
		wu = w32[WU_W-1:0];
		hu = h32[HU_W-1:0];
	end

	assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			thr_q    <= RST_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    width_q <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data;
				REG_EDGE_THRESHOLD: thr_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as a whole unless a result waits at the output.
	assign adv    = !(res_out.valid && !res_out.ready);
	assign accept = pix_in.valid && adv;
	assign pix_in.ready = adv;

	// Decide at entry whether this beat releases a result and of which kind.
	always_comb begin
		ctl_in.pixel    = !pix_in.mode;
		ctl_in.res      = 1'b0;
		ctl_in.interior = 1'b0;
		ctl_in.last     = 1'b0;
		if (pix_in.mode) begin
			ctl_in.res  = pend_q != '0;
			ctl_in.last = (row_q == '0 && 32'(col_q) == 32'(pend_q) - 32'd1)
				|| (row_q == RW'(1) && col_q == '0 && 32'(pend_q) == 32'(wu) + 32'd1);
		end else begin
			ctl_in.res      = 32'(pend_q) >= 32'(wu) + 32'd1;
			ctl_in.interior = row_q >= RW'(2) && col_q >= CW'(2);
			ctl_in.last     = !ctl_in.interior && row_q == RW'(1) && col_q == '0;
		end
	end

	// Frame position and owed count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (pix_in.mode) begin
				if (pend_q != '0) begin
					pend_q <= pend_q - PW'(1);
				end
			end else begin
				if (32'(col_q) + 32'd1 >= 32'(wu)) begin
					col_q <= '0;
					if (32'(row_q) + 32'd1 >= 32'(hu)) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (!ctl_in.res) begin
					pend_q <= pend_q + PW'(1);
				end
			end
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (adv) begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Luminance path: squares, weighted products, scaled sum.
	assign sum = 27'(pr_s2) + 27'(pg_s2) + 27'(pb_s2);

	// Square root, two digits per stage.
	assign sq4_a = sqrt_step('0, v_rad_s3[15:14]);
	assign sq4_b = sqrt_step(sq4_a, v_rad_s3[13:12]);
	assign sq5_a = sqrt_step(sq_s4, v_rad_s4[11:10]);
	assign sq5_b = sqrt_step(sq5_a, v_rad_s4[9:8]);
	assign sq6_a = sqrt_step(sq_s5, v_rad_s5[7:6]);
	assign sq6_b = sqrt_step(sq6_a, v_rad_s5[5:4]);
	assign sq7_a = sqrt_step(sq_s6, v_rad_s6[3:2]);
	assign sq7_b = sqrt_step(sq7_a, v_rad_s6[1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			col_s1 <= col_q;
			r2_s1  <= pix_in.pixel_in[23:16] * pix_in.pixel_in[23:16];
			g2_s1  <= pix_in.pixel_in[15:8] * pix_in.pixel_in[15:8];
			b2_s1  <= pix_in.pixel_in[7:0] * pix_in.pixel_in[7:0];

			ctl_s2 <= ctl_s1;
			col_s2 <= col_s1;
			pr_s2  <= 26'(r2_s1) * 26'(WGT_RED);
			pg_s2  <= 26'(g2_s1) * 26'(WGT_GREEN);
			pb_s2  <= 26'(b2_s1) * 26'(WGT_BLUE);

			ctl_s3   <= ctl_s2;
			col_s3   <= col_s2;
			v_rad_s3 <= sum[25:10];

			ctl_s4   <= ctl_s3;
			col_s4   <= col_s3;
			v_rad_s4 <= v_rad_s3;
			sq_s4    <= sq4_b;

			ctl_s5   <= ctl_s4;
			col_s5   <= col_s4;
			v_rad_s5 <= v_rad_s4;
			sq_s5    <= sq5_b;

			ctl_s6   <= ctl_s5;
			col_s6   <= col_s5;
			v_rad_s6 <= v_rad_s5;
			sq_s6    <= sq6_b;

			ctl_s7 <= ctl_s6;
			col_s7 <= col_s6;
			sq_s7  <= sq7_b;
		end
	end

	// Row stores: read as a beat enters stage 7, written as it leaves.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_up_q  <= upper_mem[col_s6];
			rd_mid_q <= middle_mem[col_s6];
			if (v_s7 && ctl_s7.pixel) begin
				upper_mem[col_s7]  <= rd_mid_q;
				middle_mem[col_s7] <= sq_s7.root;
			end
		end
	end

	// Window after shifting in the new column.
	always_comb begin
		wn[0] = win_q[1];
		wn[1] = win_q[2];
		wn[2] = rd_up_q;
		wn[3] = win_q[4];
		wn[4] = win_q[5];
		wn[5] = rd_mid_q;
		wn[6] = win_q[7];
		wn[7] = win_q[8];
		wn[8] = sq_s7.root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv && v_s7 && ctl_s7.pixel) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= wn[i];
			end
		end
	end

	// Sobel pair on the updated window.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s8 <= ctl_s7;
			dx_s8  <= $signed({1'b0, 10'(wn[2]) + 10'({wn[5], 1'b0}) + 10'(wn[8])})
				- $signed({1'b0, 10'(wn[0]) + 10'({wn[3], 1'b0}) + 10'(wn[6])});
			dy_s8  <= $signed({1'b0, 10'(wn[6]) + 10'({wn[7], 1'b0}) + 10'(wn[8])})
				- $signed({1'b0, 10'(wn[0]) + 10'({wn[1], 1'b0}) + 10'(wn[2])});
		end
	end

	// Gradient magnitude and threshold.
	always_comb begin
		ax       = dx_s8[10] ? 10'(-dx_s8) : dx_s8[9:0];
		ay       = dy_s8[10] ? 10'(-dy_s8) : dy_s8[9:0];
		power    = 11'(ax) + 11'(ay);
		edge_hit = ctl_s8.interior && ({1'b0, power} >= thr_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s9  <= ctl_s8;
			edge_s9 <= edge_hit;
			pix_s9  <= edge_hit ? EDGE_PIXEL : NO_EDGE_PIXEL;
		end
	end

	// Result register drives the output channel.
	assign res_out.valid         = v_s9 && ctl_s9.res;
	assign res_out.pixel_out     = pix_s9;
	assign res_out.is_edge       = edge_s9;
	assign res_out.last_of_frame = ctl_s9.last;

endmodule

// File: design/set_checker.sv
// Port-level checker of the Sobel edge threshold unit, bound to the top level.
// Depends on set_pkg and sobel_edge_threshold_unit_defines.svh.
`include "sobel_edge_threshold_unit_defines.svh"

module set_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_out,
	input logic        is_edge,
	input logic        last_of_frame
);
	import set_pkg::*;

	// The result word always matches the edge flag.
	`SET_ASSERT_NOW(a_word_matches_flag, out_valid,
		(is_edge && pixel_out == EDGE_PIXEL) || (!is_edge && pixel_out == NO_EDGE_PIXEL),
		"result word does not match is_edge")

	// The frame's final pixel is a border pixel and never an edge.
	`SET_ASSERT_NOW(a_last_not_edge, out_valid && last_of_frame, !is_edge,
		"last_of_frame result marked as edge")

	// Input is refused only while a result waits.
	`SET_ASSERT_NOW(a_ready_only_stall, !in_ready, out_valid && !out_ready,
		"input refused without an output stall")

	// A stalled result holds.
	`SET_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready,
		out_valid && $stable(pixel_out) && $stable(last_of_frame),
		"stalled result changed")

endmodule

bind sobel_edge_threshold_unit set_checker u_set_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (pix_in.ready),
	.out_valid     (res_out.valid),
	.out_ready     (res_out.ready),
	.pixel_out     (res_out.pixel_out),
	.is_edge       (res_out.is_edge),
	.last_of_frame (res_out.last_of_frame)
);

// File: bench/sobel_edge_threshold_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the Sobel edge threshold unit: directed rows, then random frames.
// Depends on set_pkg, the stream interfaces in set_if.sv and sobel_edge_threshold_unit.
module sobel_edge_threshold_unit_test;
	import set_pkg::*;

	localparam int MAX_W = 2048;
	localparam int MAX_H = 4096;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 24;
	localparam bit PIXEL_BEAT = 1'b0;
	localparam bit FLUSH_BEAT = 1'b1;

	typedef struct {
		logic [31:0] pixel;
		logic        edge_flag;
		logic        last;
	} edge_res_t;

	typedef struct {
		bit          mode;
		logic [31:0] pixel;
		bit          typed;   // expectation written in the row
		bit          has_res;
		edge_res_t   res;
	} table_row_t;

	typedef struct {
		logic [12:0] width_raw;
		logic [12:0] height_raw;
		logic [12:0] thr;
		int          count;
	} frame_setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	set_pix_if pix ();
	set_res_if res ();

	sobel_edge_threshold_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(pix.sink), .res_out(res.source)
	);

	always #6 clk = ~clk;

	// Mirror of the block's state used to predict each result.
	int unsigned m_width, m_height, m_thr;
	logic [7:0] m_upper [MAX_W];
	logic [7:0] m_middle [MAX_W];
	logic [7:0] m_win [9];
	int unsigned m_col, m_row, m_owed;

	edge_res_t expected_q [$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	table_row_t dir_rows [$];
	frame_setting_t settings [$];

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [7:0] luminance(logic [31:0] p);
		int unsigned r, g, b, v, root, bitv;
		r = p[23:16];
		g = p[15:8];
		b = p[7:0];
		v = (247 * r * r + 708 * g * g + 70 * b * b) >> 10;
		root = 0;
		bitv = 1 << 30;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return (root > 255) ? 8'd255 : root[7:0];
	endfunction

	function automatic edge_res_t make_res(bit e, bit last);
		edge_res_t r;
		r.pixel = e ? EDGE_PIXEL : NO_EDGE_PIXEL;
		r.edge_flag = e;
		r.last = last;
		return r;
	endfunction

	function automatic void restart_frame();
		foreach (m_win[k]) m_win[k] = '0;
		m_col = 0;
		m_row = 0;
		m_owed = 0;
	endfunction

	// Advance the mirror by one accepted beat; reports whether a result is due.
	task automatic predict_edge(input bit mode, input logic [31:0] p, output bit got,
		output edge_res_t r);
		int unsigned w, h, frame, pos, idx, c, col, row, power;
		int dx, dy;
		logic [7:0] lum;
		w = clamp_size(m_width, MAX_W);
		h = clamp_size(m_height, MAX_H);
		frame = w * h;
		col = m_col;
		row = m_row;
		pos = row * w + col;
		got = 1'b0;
		r = make_res(1'b0, 1'b0);
		if (mode == FLUSH_BEAT) begin
			if (m_owed != 0) begin
				idx = (pos >= m_owed) ? pos - m_owed : pos + frame - m_owed;
				m_owed--;
				got = 1'b1;
				r = make_res(1'b0, idx == frame - 1);
			end
			return;
		end
		// Shift the window and bring in the new column.
		lum = luminance(p);
		c = col % MAX_W;
		for (int k = 0; k < 3; k++) begin
			m_win[k*3] = m_win[k*3+1];
			m_win[k*3+1] = m_win[k*3+2];
		end
		m_win[2] = m_upper[c];
		m_win[5] = m_middle[c];
		m_win[8] = lum;
		m_upper[c] = m_middle[c];
		m_middle[c] = lum;
		if (col + 1 >= w) begin
			m_col = 0;
			m_row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			m_col = col + 1;
		end
		if (m_owed < w + 1) begin
			m_owed++;
			return;
		end
		got = 1'b1;
		if (row >= 2 && col >= 2) begin
			dx = int'(m_win[2]) + 2 * int'(m_win[5]) + int'(m_win[8])
				- (int'(m_win[0]) + 2 * int'(m_win[3]) + int'(m_win[6]));
			dy = int'(m_win[6]) + 2 * int'(m_win[7]) + int'(m_win[8])
				- (int'(m_win[0]) + 2 * int'(m_win[1]) + int'(m_win[2]));
			power = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
			r = make_res(power >= m_thr, 1'b0);
		end else begin
			idx = (pos >= w + 1) ? pos - (w + 1) : pos + frame - (w + 1);
			r = make_res(1'b0, idx == frame - 1);
		end
	endtask

	// Register write at the falling edge; the mirror follows at once.
	task automatic write_reg(input cfg_index_t idx, input logic [12:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: begin
				m_width = val[11:0];
				restart_frame();
			end
			REG_IMAGE_HEIGHT: begin
				m_height = val;
				restart_frame();
			end
			REG_EDGE_THRESHOLD: m_thr = val[11:0];
			default: ;
		endcase
	endtask

	// Let every owed result arrive and the pipeline go quiet before a write.
	task automatic wait_idle();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one beat, with bursts and gaps, and predict it once accepted.
	task automatic send_beat(input bit mode, input logic [31:0] p, input bit typed,
		input bit typed_has, input edge_res_t typed_res);
		bit got;
		edge_res_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				pix.valid = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		pix.valid = 1'b1;
		pix.mode = mode;
		pix.pixel_in = p;
		do @(posedge clk); while (!pix.ready);
		predict_edge(mode, p, got, r);
		if (typed) begin
			got = typed_has;
			r = typed_res;
		end
		if (got) expected_q.push_back(r);
	endtask

	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		p = $urandom();
		case ($urandom_range(0, 4))
			0: p[23:0] = 24'h000000;
			1: p[23:0] = 24'hffffff;
			2: p[23:0] = {3{p[7:0]}};
			default: ;
		endcase
		return p;
	endfunction

	// Receiver: the stall pattern steps through always ready, random and mostly stalled,
	// and one long hold-off starts while the sender is offering beats.
	int rx_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		rx_cycles <= rx_cycles + 1;
		if (!hold_done && rx_cycles >= 600 && pix.valid) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res.ready <= 1'b0;
		end else begin
			case ((rx_cycles / 300) % 3)
				0: res.ready <= 1'b1;
				1: res.ready <= $urandom_range(0, 1);
				default: res.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		edge_res_t e;
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result pixel_out=%h is_edge=%b last=%b",
						$time, res.pixel_out, res.is_edge, res.last_of_frame);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (res.pixel_out !== e.pixel || res.is_edge !== e.edge_flag
						|| res.last_of_frame !== e.last) begin
						$display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
							e.pixel, e.edge_flag, e.last,
							res.pixel_out, res.is_edge, res.last_of_frame);
						errors++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		table_row_t row;
		frame_setting_t s;
		edge_res_t none;
		edge_res_t no_edge;
		edge_res_t edge_hit;
		edge_res_t last_hit;
		pix.valid = 1'b0;
		pix.mode = PIXEL_BEAT;
		pix.pixel_in = '0;
		m_width = RST_WIDTH;
		m_height = RST_HEIGHT;
		m_thr = RST_THRESHOLD;
		foreach (m_upper[k]) begin
			m_upper[k] = '0;
			m_middle[k] = '0;
		end
		restart_frame();
		none = make_res(1'b0, 1'b0);
		no_edge = make_res(1'b0, 1'b0);
		edge_hit = make_res(1'b1, 1'b0);
		last_hit = make_res(1'b0, 1'b1);

		// 3x3 frame with threshold zero: borders, one interior edge, then the drain.
		dir_rows = '{
			'{PIXEL_BEAT, 32'h0000_0000, 1, 0, none},
			'{PIXEL_BEAT, 32'hffff_ffff, 1, 0, none},
			'{PIXEL_BEAT, 32'h00ff_0000, 1, 0, none},
			'{PIXEL_BEAT, 32'h0000_ff00, 1, 0, none},
			'{PIXEL_BEAT, 32'h0000_00ff, 1, 1, no_edge},
			'{PIXEL_BEAT, 32'hff00_0000, 1, 1, no_edge},
			'{PIXEL_BEAT, 32'h00ff_ffff, 1, 1, no_edge},
			'{PIXEL_BEAT, 32'h8080_8080, 1, 1, no_edge},
			'{PIXEL_BEAT, 32'h0101_0101, 1, 1, edge_hit},
			'{FLUSH_BEAT, 32'hffff_ffff, 1, 1, no_edge},
			'{FLUSH_BEAT, 32'h0000_0000, 1, 1, no_edge},
			'{FLUSH_BEAT, 32'h0000_0000, 1, 1, no_edge},
			'{FLUSH_BEAT, 32'h0000_0000, 1, 1, last_hit},
			'{FLUSH_BEAT, 32'h0000_0000, 1, 0, none},
			// Second frame: a hard step, then back to back into a third frame.
			'{PIXEL_BEAT, 32'h00ff_ffff, 0, 0, none},
			'{PIXEL_BEAT, 32'h00ff_ffff, 0, 0, none},
			'{PIXEL_BEAT, 32'h0000_0000, 0, 0, none},
			'{PIXEL_BEAT, 32'h00ff_ffff, 0, 0, none},
			'{PIXEL_BEAT, 32'h00ff_ffff, 0, 0, none},
			'{PIXEL_BEAT, 32'h0000_0000, 0, 0, none},
			'{PIXEL_BEAT, 32'h00ff_ffff, 0, 0, none},
			'{PIXEL_BEAT, 32'h0000_0000, 0, 0, none},
			'{PIXEL_BEAT, 32'h0000_0000, 0, 0, none},
			'{PIXEL_BEAT, 32'h1234_5678, 0, 0, none},
			'{PIXEL_BEAT, 32'h00aa_5533, 0, 0, none}
		};

		settings = '{
			'{13'd5, 13'd4, 13'd0, 200},
			'{13'd0, 13'd0, 13'd100, 150},
			'{13'd6, 13'd5, 13'd4095, 150},
			'{13'd8, 13'd6, 13'd2048, 150},
			'{13'd4095, 13'd3, 13'd200, 100},
			'{13'd3, 13'd8191, 13'd100, 60},
			'{13'd16, 13'd7, 13'd30, 200},
			'{13'd11, 13'd5, 13'd40, 200},
			'{13'd7, 13'd9, 13'd150, 200}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		write_reg(REG_EDGE_THRESHOLD, 13'd0);
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_beat(row.mode, row.pixel, row.typed, row.has_res, row.res);
		end
		while (m_owed != 0) send_beat(FLUSH_BEAT, 32'h0, 0, 0, none);

		// Random frames under each setting, then drained by flush beats.
		foreach (settings[i]) begin
			s = settings[i];
			@(negedge clk);
			pix.valid = 1'b0;
			burst_left = 0;
			wait_idle();
			write_reg(REG_IMAGE_WIDTH, s.width_raw);
			write_reg(REG_IMAGE_HEIGHT, s.height_raw);
			write_reg(REG_EDGE_THRESHOLD, s.thr);
			for (int n = 0; n < s.count; n++) begin
				if ($urandom_range(0, 99) < 4) send_beat(FLUSH_BEAT, $urandom(), 0, 0, none);
				else send_beat(PIXEL_BEAT, rand_pixel(), 0, 0, none);
			end
			while (m_owed != 0) send_beat(FLUSH_BEAT, $urandom(), 0, 0, none);
			send_beat(FLUSH_BEAT, $urandom(), 0, 0, none);
		end
		@(negedge clk);
		pix.valid = 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
